// File: rtl/chained_hash_map_unit_macros.svh
// Assertion macros shared by the chained hash map unit.
`ifndef CHAINED_HASH_MAP_UNIT_MACROS_SVH
`define CHAINED_HASH_MAP_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CHM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/chm_pkg.sv
// Shared types and constants of the chained hash map unit.
package chm_pkg;

    localparam int CHM_NUM_BUCKETS = 64;
    localparam int CHM_BUCKET_WAYS = 4;

    localparam int KEY_W   = 31;
    localparam int VALUE_W = 32;

    localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_PRESENT   = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    // One way of a bucket row.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Result word produced by one operation.
    typedef struct packed {
        status_t            status;
        logic               found;
        logic [VALUE_W-1:0] read_value;
    } result_t;

endpackage

// File: rtl/chm_bucket_ram.sv
// Bucket row memory: one write port, one read port with registered read data.
module chm_bucket_ram #(
    parameter int NUM_BUCKETS = 64,
    parameter int BUCKET_WAYS = 4,
    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [BKT_W-1:0]                     wr_addr,
    input  chm_pkg::entry_t [BUCKET_WAYS-1:0]    wr_row,
    input  logic                                 rd_en,
    input  logic [BKT_W-1:0]                     rd_addr,
    output chm_pkg::entry_t [BUCKET_WAYS-1:0]    rd_row
);
    import chm_pkg::*;

    entry_t [BUCKET_WAYS-1:0] mem [NUM_BUCKETS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
    end

    // Read data holds while no read is issued, so a stalled row stays put.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/chm_way_logic.sv
// Compares the ways of one bucket row and builds the updated row and the result.
module chm_way_logic #(
    parameter int BUCKET_WAYS = 4
) (
    input  chm_pkg::entry_t [BUCKET_WAYS-1:0]    row,
    input  logic [1:0]                           operation,
    input  logic [chm_pkg::KEY_W-1:0]            key,
    input  logic [chm_pkg::VALUE_W-1:0]          item_value,
    output chm_pkg::entry_t [BUCKET_WAYS-1:0]    row_next,
    output logic                                 row_write,
    output chm_pkg::result_t                     result
);
    import chm_pkg::*;

    localparam int WAY_W = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

    logic             hit_any;
    logic [WAY_W-1:0] hit_idx;
    logic             free_any;
    logic [WAY_W-1:0] free_idx;

    // Scan from the top way down so the lowest matching way wins.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int w = BUCKET_WAYS - 1; w >= 0; w--)
        begin
            if (row[w].valid && (row[w].key == key))
            begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!row[w].valid)
            begin
                free_any = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        row_next          = row;
        row_write         = 1'b0;
        result.status     = STATUS_DONE;
        result.found      = 1'b0;
        result.read_value = MISS_VALUE;
        case (op_t'(operation))
            OP_INSERT:
            begin
                if (hit_any)
                begin
                    result.status = STATUS_PRESENT;
                    result.found  = 1'b1;
                end
                else if (free_any)
                begin
                    row_next[free_idx].valid = 1'b1;
                    row_next[free_idx].key   = key;
                    row_next[free_idx].value = item_value;
                    row_write                = 1'b1;
                end
                else
                begin
                    result.status = STATUS_FULL;
                end
            end
            OP_LOOKUP:
            begin
                if (hit_any)
                begin
                    result.found      = 1'b1;
                    result.read_value = row[hit_idx].value;
                end
                else
                begin
                    result.status = STATUS_NOT_FOUND;
                end
            end
            OP_REMOVE:
            begin
                if (hit_any)
                begin
                    result.found            = 1'b1;
                    row_next[hit_idx].valid = 1'b0;
                    row_write               = 1'b1;
                end
                else
                begin
                    result.status = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                // An unused operation code leaves the store alone.
            end
        endcase
    end

endmodule

// File: rtl/chained_hash_map_unit.sv
// Top level of the chained hash map unit: control, hashing, output register.
//
// This block is a key-value map of unique 31-bit keys held in a synchronous
// memory of NUM_BUCKETS rows, each row holding BUCKET_WAYS ways of valid bit,
// key and value. A key lives in bucket key modulo NUM_BUCKETS. Each input word
// carries one operation: insert stores a pair unless the key is already there
// (the stored value is kept), lookup returns the stored value with a found
// flag, and remove clears the way that holds the key. An insert into a bucket
// whose ways are all in use is dropped and reported as bucket full. Every input
// word yields exactly one result word. After reset the block runs a clearing
// pass, one row per cycle, during which s_axis_tready stays low. An item then
// goes through a memory read, then a compare and write back of the row, when
// NUM_BUCKETS is a power of two; otherwise a step ahead of the read computes
// the bucket index through a reciprocal multiply. The single read-modify-write
// of one bucket row through the memory's registered read sets this order. A
// finished result sits in an output register, so the next word is accepted
// while it waits; an item holds in its write-back cycle only while that
// register is still full.
module chained_hash_map_unit #(
    parameter int NUM_BUCKETS = chm_pkg::CHM_NUM_BUCKETS,
    parameter int BUCKET_WAYS = chm_pkg::CHM_BUCKET_WAYS
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [30:0] key, [62:31] item_value, [63] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] read_value
    output logic [2:0]  m_axis_tuser    // [1:0] status, [2] found
);
    import chm_pkg::*;

    localparam int  BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam bit  IS_POW2  = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
    localparam logic [BKT_W-1:0] LAST_ROW = BKT_W'(NUM_BUCKETS - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [BKT_W-1:0] clr_cnt_reg;

    // Captured operation, held until its row has been written back.
    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [BKT_W-1:0]   bucket_reg;

    logic    out_valid_reg;
    result_t out_result_reg;

    logic               in_accept;
    logic [KEY_W-1:0]   in_key;
    logic [VALUE_W-1:0] in_value;
    logic               exec_go;

    logic             rd_en;
    logic [BKT_W-1:0] rd_bucket;
    logic             mem_wr_en;
    logic [BKT_W-1:0] mem_wr_addr;

    entry_t [BUCKET_WAYS-1:0] rd_row;
    entry_t [BUCKET_WAYS-1:0] upd_row;
    entry_t [BUCKET_WAYS-1:0] mem_wr_row;
    logic                     upd_write;
    result_t                  upd_result;

    assign in_key        = s_axis_tdata[KEY_W-1:0];
    assign in_value      = s_axis_tdata[KEY_W+VALUE_W-1:KEY_W];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // The row write-back and the result load happen together, and only when
    // the output register is empty or being emptied in this cycle.
    assign exec_go = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);

    // Bucket index. A power-of-two bucket count takes the low key bits at the
    // accept edge. Any other count goes through a reciprocal multiply into a
    // register, then a multiply-back, subtract and one correction step; the
    // estimated quotient is at most one short, so one subtract is enough.
    generate
        if (IS_POW2)
        begin : g_mask_hash
            assign rd_en     = in_accept;
            assign rd_bucket = in_key[BKT_W-1:0] & LAST_ROW;
        end
        else
        begin : g_recip_hash
            localparam int          SHIFT = KEY_W + $clog2(NUM_BUCKETS);
            localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / NUM_BUCKETS);

            logic [62:0]      prod_reg;
            logic [KEY_W-1:0] quot;
            logic [31:0]      quot_times_n;
            logic [31:0]      diff;
            logic [31:0]      rem;

            always_ff @(posedge clk)
            begin
                if (in_accept)
                begin
                    prod_reg <= 63'(in_key) * 63'(RECIP);
                end
            end

            assign quot         = KEY_W'(prod_reg >> SHIFT);
            assign quot_times_n = 32'(quot) * 32'(NUM_BUCKETS);
            assign diff         = {1'b0, key_reg} - quot_times_n;
            assign rem          = (diff >= 32'(NUM_BUCKETS)) ? (diff - 32'(NUM_BUCKETS)) : diff;
            assign rd_en        = (state_reg == S_HASH);
            assign rd_bucket    = BKT_W'(rem);
        end
    endgenerate

    // Memory write port: zero rows during the clearing pass, updated rows after.
    assign mem_wr_en   = (state_reg == S_CLEAR) || (exec_go && upd_write);
    assign mem_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : bucket_reg;
    assign mem_wr_row  = (state_reg == S_CLEAR) ? '0 : upd_row;

    chm_bucket_ram #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_bucket_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_row  (mem_wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_bucket),
        .rd_row  (rd_row)
    );

    chm_way_logic #(
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_way_logic (
        .row        (rd_row),
        .operation  (op_reg),
        .key        (key_reg),
        .item_value (value_reg),
        .row_next   (upd_row),
        .row_write  (upd_write),
        .result     (upd_result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = IS_POW2 ? S_EXEC : S_HASH;
                end
            end
            S_HASH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= s_axis_tuser;
            key_reg   <= in_key;
            value_reg <= in_value;
        end
        if (rd_en)
        begin
            bucket_reg <= rd_bucket;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_result_reg <= upd_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg.read_value;
    assign m_axis_tuser  = {out_result_reg.found, out_result_reg.status};

    `include "chained_hash_map_unit_macros.svh"

    // The memory is written only by the clearing pass or by a row write-back.
    `CHM_ASSERT_SAME(a_write_source, mem_wr_en,
        (state_reg == S_CLEAR) || (state_reg == S_EXEC),
        "memory written outside clearing or write-back")
    // An accepted word always moves on to hashing or to its row write-back.
    `CHM_ASSERT_NEXT(a_accept_flow, in_accept,
        (state_reg == S_HASH) || (state_reg == S_EXEC),
        "accepted word did not advance")
    // A new result appears only after a row write-back cycle.
    `CHM_ASSERT_SAME(a_result_origin, $rose(out_valid_reg),
        $past(state_reg == S_EXEC),
        "result raised without a write-back cycle")

endmodule
